// ===== rtl/vpa_pkg.sv =====
// Shared types, constants and helper functions for the vehicle PID actuation block.
// Used by vpa_mdu and vehicle_pid_actuation; depends on nothing else.
package vpa_pkg;

    // Fixed-point limits and scale factors.
    localparam logic [14:0] THROTTLE_MAX = 15'd26214;
    localparam logic [15:0] BRAKE_FULL   = 16'd32768;
    localparam logic [31:0] US_PER_S     = 32'd1000000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SPEED_P = 3'd0;
    localparam logic [2:0] REG_SPEED_I = 3'd1;
    localparam logic [2:0] REG_SPEED_D = 3'd2;
    localparam logic [2:0] REG_STEER_P = 3'd3;
    localparam logic [2:0] REG_STEER_I = 3'd4;
    localparam logic [2:0] REG_STEER_D = 3'd5;

    // Operand widths of the shared serial multiply/divide unit.
    localparam int unsigned OPA_W = 64;
    localparam int unsigned OPB_W = 32;
    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd63;

    typedef enum logic [0:0] {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } mdu_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic             start;
        mdu_op_t          op;
        logic [OPA_W-1:0] opa;
        logic [OPB_W-1:0] opb;
    } mdu_req_t;

    // Response from the arithmetic unit.
    typedef struct packed {
        logic             done;
        logic [OPA_W-1:0] result;
    } mdu_resp_t;

    // Magnitude of a signed 16-bit value.
    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        logic [15:0] m;
        begin
            m = x[15] ? 16'(-x) : 16'(x);
            return m;
        end
    endfunction

    // Magnitude of a signed 32-bit value.
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] m;
        begin
            m = x[31] ? 32'(-x) : 32'(x);
            return m;
        end
    endfunction

    // Saturate a 34-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        begin
            if (x > 34'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (x < -34'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = x[31:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/vpa_mdu.sv =====
// Shared bit-serial multiply and restoring divide unit, one bit per cycle.
// Depends on vpa_pkg for the request and response structs.
module vpa_mdu (
    input  logic              clk,
    input  logic              rst_n,
    input  vpa_pkg::mdu_req_t  req,
    output vpa_pkg::mdu_resp_t resp
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    vpa_pkg::mdu_op_t         op_reg, op_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic [vpa_pkg::OPA_W-1:0] a_reg, a_next;
    logic [vpa_pkg::OPB_W-1:0] b_reg, b_next;
    logic [vpa_pkg::OPA_W-1:0] acc_reg, acc_next;

    logic [vpa_pkg::OPB_W:0]   rem_shift;
    logic [vpa_pkg::OPB_W:0]   rem_diff;
    logic                      rem_ge;

    // Partial remainder step of the restoring divider.
    assign rem_shift = {acc_reg[vpa_pkg::OPB_W-1:0], a_reg[vpa_pkg::OPA_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, b_reg};
    assign rem_diff  = rem_shift - {1'b0, b_reg};

    // Step control: load on start, then one bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = req.opa;
            b_next    = req.opb;
            acc_next  = '0;
            cnt_next  = (req.op == vpa_pkg::MDU_DIV) ? vpa_pkg::DIV_LAST : vpa_pkg::MUL_LAST;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                vpa_pkg::MDU_MUL:
                begin
                    if (b_reg[0])
                        acc_next = acc_reg + a_reg;
                    a_next = {a_reg[vpa_pkg::OPA_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[vpa_pkg::OPB_W-1:1]};
                end
                vpa_pkg::MDU_DIV:
                begin
                    acc_next = rem_ge ? vpa_pkg::OPA_W'(rem_diff) : vpa_pkg::OPA_W'(rem_shift);
                    a_next   = {a_reg[vpa_pkg::OPA_W-2:0], rem_ge};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= vpa_pkg::MDU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign resp.done   = done_reg;
    assign resp.result = (op_reg == vpa_pkg::MDU_DIV) ? a_reg : acc_reg;

endmodule

// ===== rtl/vehicle_pid_actuation.sv =====
// Top level of the vehicle PID actuation block: sequencer, state and result registers.
// Depends on vpa_pkg and vpa_mdu.
//
//  Channel   Direction  Handshake             Payload
//  in        receive    in_valid / in_stall   measured_speed, wanted_speed, heading_error,
//                                             elapsed_us
//  out       send       out_valid / out_stall throttle_cmd, brake_cmd, steer_cmd
//  cfg       receive    cfg_write             cfg_index, cfg_data
//
// Every multiply and every divide in the shared serial unit runs as load, one bit per cycle,
// then done. A zero wanted_speed skips the speed-error divide, and a zero elapsed_us skips
// the two derivative chains.
// The input is stalled while a request is in work; it is taken again as soon as its result
// is in the output register, even if that result is still stalled.
// Reset clears gains, integrals, last errors and all control state.
module vehicle_pid_actuation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        measured_speed,
    input  logic [15:0]        wanted_speed,
    input  logic signed [15:0] heading_error,
    input  logic [15:0]        elapsed_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        throttle_cmd,
    output logic [15:0]        brake_cmd,
    output logic signed [15:0] steer_cmd,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_ERR    = 13'b0000000000010,
        ST_IS_MUL = 13'b0000000000100,
        ST_IS_DIV = 13'b0000000001000,
        ST_IH_MUL = 13'b0000000010000,
        ST_IH_DIV = 13'b0000000100000,
        ST_P_MUL  = 13'b0000001000000,
        ST_I_MUL  = 13'b0000010000000,
        ST_D_MUL1 = 13'b0000100000000,
        ST_D_MUL2 = 13'b0001000000000,
        ST_D_DIV  = 13'b0010000000000,
        ST_LAW    = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;
    logic   law_reg, law_next;

    logic [15:0]        v_reg, v_next;
    logic [15:0]        t_reg, t_next;
    logic signed [15:0] dev_reg, dev_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [15:0] e_reg, e_next;
    logic signed [15:0] last_e_reg, last_e_next;
    logic signed [15:0] last_h_reg, last_h_next;
    logic signed [31:0] sum_s_reg, sum_s_next;
    logic signed [31:0] sum_h_reg, sum_h_next;
    logic [63:0]        prod_reg, prod_next;
    logic               psign_reg, psign_next;
    logic signed [63:0] pid_reg, pid_next;

    logic signed [15:0] sp_p_reg, sp_i_reg, sp_d_reg;
    logic signed [15:0] st_p_reg, st_i_reg, st_d_reg;

    logic [14:0]        res_thr_reg, res_thr_next;
    logic [15:0]        res_brk_reg, res_brk_next;
    logic signed [15:0] res_str_reg, res_str_next;
    logic [14:0]        thr_reg, thr_next;
    logic [15:0]        brk_reg, brk_next;
    logic signed [15:0] str_reg, str_next;
    logic               out_valid_reg, out_valid_next;

    vpa_pkg::mdu_req_t  mdu_req;
    vpa_pkg::mdu_resp_t mdu_resp;

    // Operands of the law in work.
    logic signed [15:0] g_p, g_i, g_d, cur_err, cur_last;
    logic signed [31:0] cur_sum;
    logic signed [16:0] d_err;
    logic signed [16:0] v_diff;
    logic [16:0]        v_diff_mag;
    logic [16:0]        d_mag;
    logic [63:0]        res;
    logic signed [63:0] res_s;
    logic signed [33:0] sum_add;
    logic [63:0]        pid_mag;
    logic [63:0]        pid_q;
    logic               accept;

    assign accept = in_valid && !in_stall;
    assign res    = mdu_resp.result;

    assign g_p      = law_reg ? st_p_reg : sp_p_reg;
    assign g_i      = law_reg ? st_i_reg : sp_i_reg;
    assign g_d      = law_reg ? st_d_reg : sp_d_reg;
    assign cur_err  = law_reg ? dev_reg : e_reg;
    assign cur_last = law_reg ? last_h_reg : last_e_reg;
    assign cur_sum  = law_reg ? sum_h_reg : sum_s_reg;
    assign d_err    = {cur_err[15], cur_err} - {cur_last[15], cur_last};
    assign d_mag    = d_err[16] ? 17'(-d_err) : 17'(d_err);
    assign v_diff   = $signed({1'b0, v_reg}) - $signed({1'b0, t_reg});
    assign v_diff_mag = v_diff[16] ? 17'(-v_diff) : 17'(v_diff);
    assign res_s    = psign_reg ? -$signed(res) : $signed(res);
    assign pid_mag  = pid_reg[63] ? 64'(-pid_reg) : 64'(pid_reg);
    assign pid_q    = pid_mag >> 5;

    // Operand selection for the serial unit.
    always_comb
    begin
        mdu_req.start = 1'b0;
        mdu_req.op    = vpa_pkg::MDU_MUL;
        mdu_req.opa   = '0;
        mdu_req.opb   = '0;
        case (state_reg)
            ST_ERR:
            begin
                mdu_req.start = launch_reg;
                mdu_req.op    = vpa_pkg::MDU_DIV;
                mdu_req.opa   = 64'(v_diff_mag) << 12;
                mdu_req.opb   = 32'(t_reg);
            end
            ST_IS_MUL:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = 64'(vpa_pkg::mag16(e_reg));
                mdu_req.opb   = 32'(dt_reg);
            end
            ST_IH_MUL:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = 64'(vpa_pkg::mag16(dev_reg));
                mdu_req.opb   = 32'(dt_reg);
            end
            ST_IS_DIV, ST_IH_DIV:
            begin
                mdu_req.start = launch_reg;
                mdu_req.op    = vpa_pkg::MDU_DIV;
                mdu_req.opa   = prod_reg << 8;
                mdu_req.opb   = vpa_pkg::US_PER_S;
            end
            ST_P_MUL:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = 64'(vpa_pkg::mag16(g_p));
                mdu_req.opb   = 32'(vpa_pkg::mag16(cur_err));
            end
            ST_I_MUL:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = 64'(vpa_pkg::mag32(cur_sum));
                mdu_req.opb   = 32'(vpa_pkg::mag16(g_i));
            end
            ST_D_MUL1:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = 64'(d_mag);
                mdu_req.opb   = 32'(vpa_pkg::mag16(g_d));
            end
            ST_D_MUL2:
            begin
                mdu_req.start = launch_reg;
                mdu_req.opa   = prod_reg;
                mdu_req.opb   = vpa_pkg::US_PER_S;
            end
            ST_D_DIV:
            begin
                mdu_req.start = launch_reg;
                mdu_req.op    = vpa_pkg::MDU_DIV;
                mdu_req.opa   = prod_reg;
                mdu_req.opb   = 32'(dt_reg);
            end
            default:
            begin
                mdu_req.start = 1'b0;
            end
        endcase
    end

    vpa_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .resp  (mdu_resp)
    );

    // Sequencer: walks the error, integral and PID steps of one request.
    always_comb
    begin
        state_next   = state_reg;
        launch_next  = launch_reg && !mdu_req.start;
        law_next     = law_reg;
        v_next       = v_reg;
        t_next       = t_reg;
        dev_next     = dev_reg;
        dt_next      = dt_reg;
        e_next       = e_reg;
        last_e_next  = last_e_reg;
        last_h_next  = last_h_reg;
        sum_s_next   = sum_s_reg;
        sum_h_next   = sum_h_reg;
        prod_next    = prod_reg;
        psign_next   = psign_reg;
        pid_next     = pid_reg;
        res_thr_next = res_thr_reg;
        res_brk_next = res_brk_reg;
        res_str_next = res_str_reg;
        thr_next     = thr_reg;
        brk_next     = brk_reg;
        str_next     = str_reg;
        out_valid_next = out_valid_reg && out_stall;
        sum_add      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next      = measured_speed;
                    t_next      = wanted_speed;
                    dev_next    = heading_error;
                    dt_next     = elapsed_us;
                    launch_next = 1'b1;
                    if (wanted_speed == 16'd0)
                    begin
                        e_next     = 16'sh7FFF;
                        state_next = ST_IS_MUL;
                    end
                    else
                    begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR:
            begin
                if (mdu_resp.done)
                begin
                    if (v_diff[16])
                        e_next = (res > 64'd32768) ? 16'sh8000 : 16'(-res[15:0]);
                    else
                        e_next = (res > 64'd32767) ? 16'sh7FFF : res[15:0];
                    state_next  = ST_IS_MUL;
                    launch_next = 1'b1;
                end
            end
            ST_IS_MUL:
            begin
                if (mdu_resp.done)
                begin
                    prod_next   = res;
                    psign_next  = e_reg[15];
                    state_next  = ST_IS_DIV;
                    launch_next = 1'b1;
                end
            end
            ST_IS_DIV:
            begin
                if (mdu_resp.done)
                begin
                    sum_add     = {{2{sum_s_reg[31]}}, sum_s_reg} + res_s[33:0];
                    sum_s_next  = vpa_pkg::sat32(sum_add);
                    state_next  = ST_IH_MUL;
                    launch_next = 1'b1;
                end
            end
            ST_IH_MUL:
            begin
                if (mdu_resp.done)
                begin
                    prod_next   = res;
                    psign_next  = dev_reg[15];
                    state_next  = ST_IH_DIV;
                    launch_next = 1'b1;
                end
            end
            ST_IH_DIV:
            begin
                if (mdu_resp.done)
                begin
                    sum_add     = {{2{sum_h_reg[31]}}, sum_h_reg} + res_s[33:0];
                    sum_h_next  = vpa_pkg::sat32(sum_add);
                    law_next    = 1'b0;
                    psign_next  = sp_p_reg[15] ^ e_reg[15];
                    state_next  = ST_P_MUL;
                    launch_next = 1'b1;
                end
            end
            ST_P_MUL:
            begin
                if (mdu_resp.done)
                begin
                    pid_next    = res_s;
                    psign_next  = g_i[15] ^ cur_sum[31];
                    state_next  = ST_I_MUL;
                    launch_next = 1'b1;
                end
            end
            ST_I_MUL:
            begin
                if (mdu_resp.done)
                begin
                    // The integral term is scaled down by 256, truncating the magnitude.
                    pid_next    = pid_reg + (psign_reg ? -$signed(res >> 8) : $signed(res >> 8));
                    psign_next  = g_d[15] ^ d_err[16];
                    state_next  = (dt_reg == 16'd0) ? ST_LAW : ST_D_MUL1;
                    launch_next = 1'b1;
                end
            end
            ST_D_MUL1:
            begin
                if (mdu_resp.done)
                begin
                    prod_next   = res;
                    state_next  = ST_D_MUL2;
                    launch_next = 1'b1;
                end
            end
            ST_D_MUL2:
            begin
                if (mdu_resp.done)
                begin
                    prod_next   = res;
                    state_next  = ST_D_DIV;
                    launch_next = 1'b1;
                end
            end
            ST_D_DIV:
            begin
                if (mdu_resp.done)
                begin
                    pid_next   = pid_reg + res_s;
                    state_next = ST_LAW;
                end
            end
            ST_LAW:
            begin
                // Map the PID sum of the law in work onto its command.
                if (!law_reg)
                begin
                    if (pid_reg[63])
                    begin
                        res_thr_next = (pid_q > 64'(vpa_pkg::THROTTLE_MAX)) ?
                                       vpa_pkg::THROTTLE_MAX : pid_q[14:0];
                        res_brk_next = '0;
                    end
                    else
                    begin
                        res_thr_next = '0;
                        res_brk_next = vpa_pkg::BRAKE_FULL;
                    end
                    law_next    = 1'b1;
                    psign_next  = st_p_reg[15] ^ dev_reg[15];
                    state_next  = ST_P_MUL;
                    launch_next = 1'b1;
                end
                else
                begin
                    if (pid_reg[63])
                        res_str_next = (pid_q > 64'd32768) ? 16'sh8000 : 16'(-pid_q[15:0]);
                    else
                        res_str_next = (pid_q > 64'd32767) ? 16'sh7FFF : pid_q[15:0];
                    last_e_next = e_reg;
                    last_h_next = dev_reg;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    thr_next       = res_thr_reg;
                    brk_next       = res_brk_reg;
                    str_next       = res_str_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            law_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            last_e_reg    <= '0;
            last_h_reg    <= '0;
            sum_s_reg     <= '0;
            sum_h_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            law_reg       <= law_next;
            out_valid_reg <= out_valid_next;
            last_e_reg    <= last_e_next;
            last_h_reg    <= last_h_next;
            sum_s_reg     <= sum_s_next;
            sum_h_reg     <= sum_h_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        t_reg       <= t_next;
        dev_reg     <= dev_next;
        dt_reg      <= dt_next;
        e_reg       <= e_next;
        prod_reg    <= prod_next;
        psign_reg   <= psign_next;
        pid_reg     <= pid_next;
        res_thr_reg <= res_thr_next;
        res_brk_reg <= res_brk_next;
        res_str_reg <= res_str_next;
        thr_reg     <= thr_next;
        brk_reg     <= brk_next;
        str_reg     <= str_next;
    end

    // Gain registers written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_p_reg <= '0;
            sp_i_reg <= '0;
            sp_d_reg <= '0;
            st_p_reg <= '0;
            st_i_reg <= '0;
            st_d_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vpa_pkg::REG_SPEED_P: sp_p_reg <= cfg_data;
                vpa_pkg::REG_SPEED_I: sp_i_reg <= cfg_data;
                vpa_pkg::REG_SPEED_D: sp_d_reg <= cfg_data;
                vpa_pkg::REG_STEER_P: st_p_reg <= cfg_data;
                vpa_pkg::REG_STEER_I: st_i_reg <= cfg_data;
                vpa_pkg::REG_STEER_D: st_d_reg <= cfg_data;
                default:
                begin
                    sp_p_reg <= sp_p_reg;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign throttle_cmd = thr_reg;
    assign brake_cmd    = brk_reg;
    assign steer_cmd    = str_reg;

endmodule

// ===== rtl/vpa_checker.sv =====
// Port-level checker for the vehicle PID actuation block, bound to its top level.
// Depends on the port list of vehicle_pid_actuation.
module vpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [14:0] throttle_cmd,
    input logic [15:0] brake_cmd
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result was withdrawn");

    // A request in work blocks the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in work");

    // Braking and throttle never show together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (brake_cmd != 16'd0) |-> (throttle_cmd == 15'd0))
        else $error("throttle and brake both active");

    // Brake is either off or full, and throttle stays under its cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((brake_cmd == 16'd0) || (brake_cmd == 16'd32768))
                      && (throttle_cmd <= 15'd26214))
        else $error("command outside its range");

endmodule

bind vehicle_pid_actuation vpa_checker u_vpa_checker (.*);
